// ===== sv/stt_pkg.sv =====
// types and constants shared by the transposition table files
`default_nettype none

package stt_pkg;

    localparam int SLOT_BITS = 8;
    localparam int SLOTS     = 1 << SLOT_BITS;
    localparam int COUNT_W   = SLOT_BITS + 1;

    localparam logic       REQ_PROBE   = 1'b0;
    localparam logic       REQ_STORE   = 1'b1;
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    typedef struct packed {
        logic               has_move;
        logic [3:0]         to_col;
        logic [3:0]         to_row;
        logic [3:0]         from_col;
        logic [3:0]         from_row;
        logic [1:0]         bound_kind;
        logic signed [23:0] score;
        logic signed [6:0]  depth;
    } payload_t;

    typedef struct packed {
        logic [63:0] key;
        payload_t    payload;
    } entry_t;

    typedef struct packed {
        logic               req_type;
        logic [63:0]        key;
        logic signed [6:0]  depth;
        logic signed [23:0] alpha;
        logic signed [23:0] beta;
        logic signed [23:0] score;
        logic [1:0]         bound_kind;
        logic [3:0]         from_row;
        logic [3:0]         from_col;
        logic [3:0]         to_row;
        logic [3:0]         to_col;
        logic               has_move;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic signed [23:0] hit_score;
        logic signed [23:0] alpha_out;
        logic signed [23:0] beta_out;
        logic               move_valid;
        logic [3:0]         move_from_row;
        logic [3:0]         move_from_col;
        logic [3:0]         move_to_row;
        logic [3:0]         move_to_col;
        logic               written;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/stt_ifs.sv =====
// request and response channel interfaces
`default_nettype none

interface stt_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [63:0]        key;
    logic signed [6:0]  depth;
    logic signed [23:0] alpha;
    logic signed [23:0] beta;
    logic signed [23:0] score;
    logic [1:0]         bound_kind;
    logic [3:0]         from_row;
    logic [3:0]         from_col;
    logic [3:0]         to_row;
    logic [3:0]         to_col;
    logic               has_move;

    modport source (output valid, req_type, key, depth, alpha, beta, score, bound_kind,
                    from_row, from_col, to_row, to_col, has_move, input ready);
    modport sink (input valid, req_type, key, depth, alpha, beta, score, bound_kind,
                  from_row, from_col, to_row, to_col, has_move, output ready);
endinterface

interface stt_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [23:0] hit_score;
    logic signed [23:0] alpha_out;
    logic signed [23:0] beta_out;
    logic               move_valid;
    logic [3:0]         move_from_row;
    logic [3:0]         move_from_col;
    logic [3:0]         move_to_row;
    logic [3:0]         move_to_col;
    logic               written;

    modport source (output valid, hit, hit_score, alpha_out, beta_out, move_valid,
                    move_from_row, move_from_col, move_to_row, move_to_col, written,
                    input ready);
    modport sink (input valid, hit, hit_score, alpha_out, beta_out, move_valid,
                  move_from_row, move_from_col, move_to_row, move_to_col, written,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/stt_eval.sv =====
// probe evaluation: applies a stored bound to the search window
`default_nettype none

module stt_eval
    import stt_pkg::*;
(
    input  req_t     req,
    input  logic     found,
    input  payload_t ent,
    output res_t     res
);

    logic               hit;
    logic signed [23:0] a_n;
    logic signed [23:0] b_n;

    always_comb
    begin
        hit = 1'b0;
        a_n = req.alpha;
        b_n = req.beta;
        res = '0;
        if (found)
        begin
            if (ent.has_move)
            begin
                res.move_valid    = 1'b1;
                res.move_from_row = ent.from_row;
                res.move_from_col = ent.from_col;
                res.move_to_row   = ent.to_row;
                res.move_to_col   = ent.to_col;
            end
            if (ent.depth >= req.depth)
            begin
                case (ent.bound_kind)
                    BOUND_EXACT: hit = 1'b1;
                    BOUND_LOWER:
                    begin
                        if (ent.score >= req.beta)
                            hit = 1'b1;
                        else if (ent.score > req.alpha)
                            a_n = ent.score;
                    end
                    BOUND_UPPER:
                    begin
                        if (ent.score <= req.alpha)
                            hit = 1'b1;
                        else if (ent.score < req.beta)
                            b_n = ent.score;
                    end
                    default: hit = 1'b0;
                endcase
                // closed window hits regardless of the bound
                if (!hit && (a_n >= b_n))
                    hit = 1'b1;
            end
        end
        res.hit       = hit;
        res.hit_score = hit ? ent.score : 24'sd0;
        res.alpha_out = a_n;
        res.beta_out  = b_n;
        res.written   = 1'b0;
    end

endmodule

`default_nettype wire

// ===== sv/search_transposition_table_unit.sv =====
// transposition table top level: linear-probed exact-key table in one memory
//
//  channel | role | contents
//  req     | in   | probe or store transaction, key, window, entry to record
//  rsp     | out  | hit, score, narrowed window, best move, written flag
//
// one transaction at a time: it is taken in the idle state, then each occupied
// slot compared costs one memory read (look state) and one key compare
// (compare state), the empty slot that ends a chain is seen in the look state
// alone, and the done state finishes the transaction.
// reset clears the valid bits and the entry count at once; no clearing pass.
// a waiting response stalls only the finishing step; a new transaction is
// taken while the last response is still held.
`default_nettype none

module search_transposition_table_unit
    import stt_pkg::*;
#(
    parameter int TABLE_LIMIT = 255
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    stt_req_if.sink    req,
    stt_rsp_if.source  rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [SLOT_BITS-1:0] cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic                 full_reg, full_next;
    payload_t             ent_reg, ent_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    res_t                 rsp_reg, rsp_next;

    entry_t               mem [SLOTS];
    entry_t               rdata_reg;
    logic                 mem_we;
    entry_t               mem_wdata;

    req_t                 req_in;
    res_t                 probe_res;

    assign req_in = '{req_type: req.req_type, key: req.key, depth: req.depth,
                      alpha: req.alpha, beta: req.beta, score: req.score,
                      bound_kind: req.bound_kind, from_row: req.from_row,
                      from_col: req.from_col, to_row: req.to_row,
                      to_col: req.to_col, has_move: req.has_move};

    assign req.ready = (state_reg == ST_IDLE);

    stt_eval u_eval (
        .req   (req_reg),
        .found (found_reg),
        .ent   (ent_reg),
        .res   (probe_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[slot_reg] <= mem_wdata;
        rdata_reg <= mem[slot_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        ent_next       = ent_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_wdata      = '{key: req_reg.key,
                           payload: '{has_move: req_reg.has_move, to_col: req_reg.to_col,
                                      to_row: req_reg.to_row, from_col: req_reg.from_col,
                                      from_row: req_reg.from_row,
                                      bound_kind: req_reg.bound_kind,
                                      score: req_reg.score, depth: req_reg.depth}};

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_next   = req_in;
                    slot_next  = req.key[SLOT_BITS-1:0];
                    cnt_next   = '0;
                    found_next = 1'b0;
                    full_next  = 1'b0;
                    // overfull table is flushed before the store
                    if (req.req_type == REQ_STORE && 32'(count_reg) > TABLE_LIMIT)
                    begin
                        valid_next = '0;
                        count_next = '0;
                    end
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (!valid_reg[slot_reg])
                    state_next = ST_DONE;
                else
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (rdata_reg.key == req_reg.key)
                begin
                    found_next = 1'b1;
                    ent_next   = rdata_reg.payload;
                    state_next = ST_DONE;
                end
                else if (cnt_reg == {SLOT_BITS{1'b1}})
                begin
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (req_reg.req_type == REQ_PROBE)
                        rsp_next = probe_res;
                    else
                    begin
                        rsp_next = '0;
                        if (!full_reg && !(found_reg && ent_reg.depth > req_reg.depth))
                        begin
                            mem_we           = 1'b1;
                            rsp_next.written = 1'b1;
                            if (!found_reg)
                            begin
                                valid_next[slot_reg] = 1'b1;
                                count_next           = count_reg + 1'b1;
                            end
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        slot_reg  <= slot_next;
        cnt_reg   <= cnt_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        ent_reg   <= ent_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.hit           = rsp_reg.hit;
    assign rsp.hit_score     = rsp_reg.hit_score;
    assign rsp.alpha_out     = rsp_reg.alpha_out;
    assign rsp.beta_out      = rsp_reg.beta_out;
    assign rsp.move_valid    = rsp_reg.move_valid;
    assign rsp.move_from_row = rsp_reg.move_from_row;
    assign rsp.move_from_col = rsp_reg.move_from_col;
    assign rsp.move_to_row   = rsp_reg.move_to_row;
    assign rsp.move_to_col   = rsp_reg.move_to_col;
    assign rsp.written       = rsp_reg.written;

endmodule

`default_nettype wire
